>>> hw/rtl/stack_machine_branch_unit_core_assert.svh
// Assertion macros for the return-address-stack branch unit.
`ifndef STACK_MACHINE_BRANCH_UNIT_CORE_ASSERT_SVH
`define STACK_MACHINE_BRANCH_UNIT_CORE_ASSERT_SVH

// Same-cycle implication, masked during reset.
`define SMBU_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, masked during reset.
`define SMBU_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/smbu_pkg.sv
// Shared codes and types of the return-address-stack branch unit.
`default_nettype none

package smbu_pkg;

    localparam logic [2:0] KIND_JUMP = 3'd0;
    localparam logic [2:0] KIND_JZ   = 3'd1;
    localparam logic [2:0] KIND_JNZ  = 3'd2;
    localparam logic [2:0] KIND_CALL = 3'd3;
    localparam logic [2:0] KIND_RET  = 3'd4;

    localparam logic [1:0] ERR_NONE       = 2'd0;
    localparam logic [1:0] ERR_DATA_UNDER = 2'd1;
    localparam logic [1:0] ERR_CALL_OVER  = 2'd2;
    localparam logic [1:0] ERR_CALL_UNDER = 2'd3;

    // Status of one decoded flow word; from_stack selects the RAM read data as next ip.
    typedef struct packed {
        logic       pop;
        logic       halt;
        logic [1:0] err;
        logic       from_stack;
    } flags_t;

endpackage

`default_nettype wire

>>> hw/rtl/smbu_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module smbu_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/smbu_ctrl.sv
// Flow-word decode and return-stack depth tracking, driving the stack RAM ports.
`default_nettype none

module smbu_ctrl #(
    parameter int STACK_DEPTH = 128,
    parameter int ADDR_BITS   = 16
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             issue,
    input  wire logic [2:0]                       kind,
    input  wire logic [ADDR_BITS-1:0]             current_ip,
    input  wire logic [ADDR_BITS-1:0]             target,
    input  wire logic                             data_empty,
    input  wire logic signed [31:0]               top_value,
    output logic      [ADDR_BITS-1:0]             next_ip,
    output smbu_pkg::flags_t                      flags,
    output logic      [$clog2(STACK_DEPTH+1)-1:0] depth,
    output logic                                  ram_we,
    output logic      [$clog2(STACK_DEPTH)-1:0]   ram_waddr,
    output logic      [ADDR_BITS-1:0]             ram_wdata,
    output logic                                  ram_re,
    output logic      [$clog2(STACK_DEPTH)-1:0]   ram_raddr
);

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int DW = $clog2(STACK_DEPTH + 1);

    logic [DW-1:0]        depth_reg;
    logic [DW-1:0]        depth_next;
    logic [DW-1:0]        depth_m1;
    logic [ADDR_BITS-1:0] after;
    logic                 full;
    logic                 rs_empty;
    logic                 top_zero;
    logic                 push;
    logic                 pull;

    assign after    = current_ip + {{(ADDR_BITS-1){1'b0}}, 1'b1};
    assign full     = (depth_reg == DW'(STACK_DEPTH));
    assign rs_empty = (depth_reg == '0);
    assign top_zero = (top_value == '0);
    assign depth_m1 = depth_reg - {{(DW-1){1'b0}}, 1'b1};

    always_comb
    begin
        next_ip = current_ip;
        flags   = '0;
        push    = 1'b0;
        pull    = 1'b0;
        unique case (kind) inside
            smbu_pkg::KIND_JUMP:
            begin
                next_ip = target;
            end
            smbu_pkg::KIND_JZ, smbu_pkg::KIND_JNZ:
            begin
                next_ip = after;
                if (data_empty)
                begin
                    flags.halt = 1'b1;
                    flags.err  = smbu_pkg::ERR_DATA_UNDER;
                end
                else
                begin
                    flags.pop = 1'b1;
                    if ((kind == smbu_pkg::KIND_JZ) == top_zero)
                    begin
                        next_ip = target;
                    end
                end
            end
            smbu_pkg::KIND_CALL:
            begin
                if (full)
                begin
                    next_ip    = after;
                    flags.halt = 1'b1;
                    flags.err  = smbu_pkg::ERR_CALL_OVER;
                end
                else
                begin
                    push    = 1'b1;
                    next_ip = target;
                end
            end
            smbu_pkg::KIND_RET:
            begin
                if (rs_empty)
                begin
                    flags.halt = 1'b1;
                    flags.err  = smbu_pkg::ERR_CALL_UNDER;
                end
                else
                begin
                    pull             = 1'b1;
                    flags.from_stack = 1'b1;
                end
            end
            default:
            begin
                next_ip = current_ip;
            end
        endcase
    end

    always_comb
    begin
        depth_next = depth_reg;
        if (issue && push)
        begin
            depth_next = depth_reg + {{(DW-1){1'b0}}, 1'b1};
        end
        else if (issue && pull)
        begin
            depth_next = depth_m1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg <= '0;
        end
        else
        begin
            depth_reg <= depth_next;
        end
    end

    // A return straight after a call reads the entry that call wrote.
    assign ram_we    = issue && push;
    assign ram_waddr = depth_reg[AW-1:0];
    assign ram_wdata = after;
    assign ram_re    = issue && pull;
    assign ram_raddr = depth_m1[AW-1:0];
    assign depth     = depth_reg;

endmodule

`default_nettype wire

>>> hw/rtl/stack_machine_branch_unit_core.sv
// An accepted word is registered in the pending stage, then in the output register.
// One word per cycle while in_ready holds; the stack RAM read sits in the pending stage.
// The output register frees the pending stage, so input stalls only while both are full.
// Reset clears the return depth and all valid flags; RAM contents stay undefined
// and need no clearing pass, as only written entries are ever read.
`default_nettype none
`include "stack_machine_branch_unit_core_assert.svh"

module stack_machine_branch_unit_core #(
    parameter int STACK_DEPTH = 128,
    parameter int ADDR_BITS   = 16
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [2:0]           kind,
    input  wire logic [ADDR_BITS-1:0] current_ip,
    input  wire logic [ADDR_BITS-1:0] target,
    input  wire logic                 data_empty,
    input  wire logic signed [31:0]   top_value,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic      [ADDR_BITS-1:0] next_ip,
    output logic                      pop_data,
    output logic                      halt,
    output logic      [1:0]           error_code
);

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int DW = $clog2(STACK_DEPTH + 1);

    logic                 accept;
    logic                 pend_move;
    logic [ADDR_BITS-1:0] dec_ip;
    smbu_pkg::flags_t     dec_flags;
    logic [DW-1:0]        depth;
    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    logic [ADDR_BITS-1:0] ram_wdata;
    logic                 ram_re;
    logic [AW-1:0]        ram_raddr;
    logic [ADDR_BITS-1:0] ram_rdata;

    logic                 pend_valid_reg;
    logic                 pend_valid_next;
    logic [ADDR_BITS-1:0] pend_ip_reg;
    smbu_pkg::flags_t     pend_flags_reg;
    logic [ADDR_BITS-1:0] pend_result_ip;

    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [ADDR_BITS-1:0] next_ip_reg;
    logic                 pop_data_reg;
    logic                 halt_reg;
    logic [1:0]           error_code_reg;

    assign pend_move = pend_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !pend_valid_reg || pend_move;
    assign accept    = in_valid && in_ready;

    smbu_ctrl #(
        .STACK_DEPTH (STACK_DEPTH),
        .ADDR_BITS   (ADDR_BITS)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .issue      (accept),
        .kind       (kind),
        .current_ip (current_ip),
        .target     (target),
        .data_empty (data_empty),
        .top_value  (top_value),
        .next_ip    (dec_ip),
        .flags      (dec_flags),
        .depth      (depth),
        .ram_we     (ram_we),
        .ram_waddr  (ram_waddr),
        .ram_wdata  (ram_wdata),
        .ram_re     (ram_re),
        .ram_raddr  (ram_raddr)
    );

    smbu_ram #(
        .WIDTH (ADDR_BITS),
        .DEPTH (STACK_DEPTH)
    ) u_stack_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // RAM read data holds while the pending word stalls: reads fire only on accept.
    assign pend_result_ip = pend_flags_reg.from_stack ? ram_rdata : pend_ip_reg;

    always_comb
    begin
        pend_valid_next = pend_valid_reg;
        if (accept)
        begin
            pend_valid_next = 1'b1;
        end
        else if (pend_move)
        begin
            pend_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (pend_move)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pend_ip_reg    <= dec_ip;
            pend_flags_reg <= dec_flags;
        end
        if (pend_move)
        begin
            next_ip_reg    <= pend_result_ip;
            pop_data_reg   <= pend_flags_reg.pop;
            halt_reg       <= pend_flags_reg.halt;
            error_code_reg <= pend_flags_reg.err;
        end
    end

    assign out_valid  = out_valid_reg;
    assign next_ip    = next_ip_reg;
    assign pop_data   = pop_data_reg;
    assign halt       = halt_reg;
    assign error_code = error_code_reg;

    `SMBU_ASSERT_IMP(a_depth_bound, clk, rst_n, 1'b1, depth <= DW'(STACK_DEPTH), "return depth beyond stack size")
    `SMBU_ASSERT_NXT(a_call_push, clk, rst_n, accept && kind == smbu_pkg::KIND_CALL && dec_flags.err == smbu_pkg::ERR_NONE, depth == $past(depth) + DW'(1), "call did not raise depth")
    `SMBU_ASSERT_IMP(a_halt_err, clk, rst_n, out_valid_reg, (halt_reg == (error_code_reg != smbu_pkg::ERR_NONE)) && !(pop_data_reg && halt_reg), "halt, error and pop disagree")

endmodule

`default_nettype wire
